@@ hw/rtl/rle_pkg.sv @@
// Shared widths, codes and reset values for the redundant leader election block.
package rle_pkg;

   localparam int SCORE_W = 26;
   localparam int ID_W    = 2;
   localparam int MASK_W  = 4;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int NOW_W   = 48;

   localparam int NODE_COUNT_DEFAULT = 4;
   localparam int TIME_BITS_DEFAULT  = 48;

   localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(65470464);

   localparam logic [ID_W-1:0]    OWN_ID_RESET  = '0;
   localparam logic [CSR_W-1:0]   TIMEOUT_RESET = CSR_W'(100000);
   localparam logic [SCORE_W-1:0] MARGIN_RESET  = SCORE_W'(6554);
   localparam logic [CSR_W-1:0]   HOLDOFF_RESET = CSR_W'(500000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID  = 2'd0,
      CSR_TIMEOUT = 2'd1,
      CSR_MARGIN  = 2'd2,
      CSR_HOLDOFF = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_PEER = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   function automatic logic [SCORE_W-1:0] sat_score(input logic [SCORE_W-1:0] s);
      sat_score = (s > SCORE_MAX) ? SCORE_MAX : s;
   endfunction

endpackage

@@ hw/rtl/redundant_leader_election.sv @@
// Leader election over a table of redundant nodes, with margin and holdoff hysteresis.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         taken when start is high and busy is low
//   response  rsp_valid, rsp_*           one-cycle strobe, one response per request
//   config    csr_we, csr_index, csr_*   written on every edge with csr_we high
//
// A peer report goes straight to the finish state; a tick makes one pass of the shared
// subtract-and-compare unit over the table for expiry, a holdoff check, a fetch of the
// leader's score and a second pass for the election scan.
// The response strobe rises in the cycle that busy falls.
// Synchronous reset clears the table, the leader and the local score at once.
// The receiver cannot stall; a response is never held back.
module redundant_leader_election #(
   parameter int NODE_COUNT = rle_pkg::NODE_COUNT_DEFAULT,
   parameter int TIME_BITS  = rle_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [rle_pkg::ID_W-1:0]      req_node_index,
   input  logic [rle_pkg::SCORE_W-1:0]   req_score_value,
   input  logic                          req_local_fresh,
   input  logic                          req_local_healthy,
   input  logic [rle_pkg::NOW_W-1:0]     req_now_us,
   output logic                          rsp_valid,
   output logic [rle_pkg::ID_W-1:0]      rsp_leader_id,
   output logic                          rsp_leader_changed,
   output logic [rle_pkg::MASK_W-1:0]    rsp_valid_mask,
   output logic [rle_pkg::SCORE_W-1:0]   rsp_self_score_out,
   input  logic                          csr_we,
   input  logic [rle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rle_pkg::CSR_W-1:0]     csr_wdata
);
   import rle_pkg::*;

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int LEAD_W = (IDX_W > ID_W) ? IDX_W : ID_W;
   localparam logic [LEAD_W:0]  NODE_LIM  = (LEAD_W + 1)'(NODE_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODE_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_LOCAL,
      ST_LEAD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [SCORE_W-1:0]   score_ff [NODE_COUNT];
   logic [SCORE_W-1:0]   score_in [NODE_COUNT];
   logic [TIME_BITS-1:0] seen_ff  [NODE_COUNT];
   logic [TIME_BITS-1:0] seen_in  [NODE_COUNT];
   logic [NODE_COUNT-1:0] valid_ff, valid_in;

   logic [ID_W-1:0]      own_ff, own_in;
   logic [CSR_W-1:0]     timeout_ff, timeout_in;
   logic [SCORE_W-1:0]   margin_ff, margin_in;
   logic [CSR_W-1:0]     holdoff_ff, holdoff_in;

   logic [LEAD_W-1:0]    leader_ff, leader_in;
   logic [TIME_BITS-1:0] last_change_ff, last_change_in;
   logic [SCORE_W-1:0]   local_ff, local_in;

   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 mode_ff, mode_in;
   logic [SCORE_W-1:0]   req_score_ff, req_score_in;
   logic                 fresh_ff, fresh_in;
   logic                 healthy_ff, healthy_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SCORE_W-1:0]   best_ff, best_in;
   logic [LEAD_W-1:0]    best_id_ff, best_id_in;
   logic                 holdoff_ok_ff, holdoff_ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_leader_ff, rsp_leader_in;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [SCORE_W-1:0]   rd_score;
   logic [TIME_BITS-1:0] rd_seen;
   logic                 rd_valid;

   logic [TIME_BITS-1:0] op_a, op_b, op_c;
   logic [TIME_BITS:0]   diff;
   logic                 borrow;
   logic                 gt;

   logic                 accept;
   logic [LEAD_W-1:0]    peer_idx;
   logic [LEAD_W-1:0]    own_idx;
   logic                 leader_in_range;
   logic                 own_in_range;
   logic                 peer_in_range;
   logic [SCORE_W-1:0]   local_new;
   logic [MASK_W-1:0]    mask_now;

   assign accept          = start && (state_ff == ST_IDLE);
   assign peer_idx        = LEAD_W'(req_node_index);
   assign own_idx         = LEAD_W'(own_ff);
   assign leader_in_range = {1'b0, leader_ff} < NODE_LIM;
   assign own_in_range    = {1'b0, own_idx} < NODE_LIM;
   assign peer_in_range   = {1'b0, peer_idx} < NODE_LIM;

   // Read port of the node table: the scan counter, or the leader while its score is fetched.
   always_comb begin
      rd_addr = (state_ff == ST_LEAD) ? leader_ff[IDX_W-1:0] : cnt_ff;
   end
   assign rd_score = score_ff[rd_addr];
   assign rd_seen  = seen_ff[rd_addr];
   assign rd_valid = valid_ff[rd_addr];

   // Shared unit: one wrapping subtraction with borrow, then one greater-than compare.
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      unique case (state_ff)
         ST_EXPIRE: begin
            op_a = now_ff;
            op_b = rd_seen;
            op_c = TIME_BITS'(timeout_ff);
         end
         ST_LOCAL: begin
            op_a = now_ff;
            op_b = last_change_ff;
            op_c = TIME_BITS'(holdoff_ff);
         end
         ST_SCAN: begin
            op_a = TIME_BITS'(best_ff);
            op_b = TIME_BITS'(rd_score);
            op_c = TIME_BITS'(margin_ff);
         end
         default: begin
            op_a = '0;
         end
      endcase
   end
   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign borrow = diff[TIME_BITS];
   assign gt     = diff[TIME_BITS-1:0] > op_c;

   always_comb begin
      local_new = local_ff;
      if (fresh_ff) begin
         local_new = healthy_ff ? sat_score(req_score_ff) : SCORE_MAX;
      end
   end

   always_comb begin
      mask_now = '0;
      for (int i = 0; i < MASK_W && i < NODE_COUNT; i++) begin
         mask_now[i] = valid_ff[i];
      end
   end

   always_comb begin
      state_in       = state_ff;
      score_in       = score_ff;
      seen_in        = seen_ff;
      valid_in       = valid_ff;
      own_in         = own_ff;
      timeout_in     = timeout_ff;
      margin_in      = margin_ff;
      holdoff_in     = holdoff_ff;
      leader_in      = leader_ff;
      last_change_in = last_change_ff;
      local_in       = local_ff;
      cnt_in         = cnt_ff;
      mode_in        = mode_ff;
      req_score_in   = req_score_ff;
      fresh_in       = fresh_ff;
      healthy_in     = healthy_ff;
      now_in         = now_ff;
      best_in        = best_ff;
      best_id_in     = best_id_ff;
      holdoff_ok_in  = holdoff_ok_ff;
      rsp_valid_in   = 1'b0;
      rsp_leader_in  = rsp_leader_ff;
      rsp_changed_in = 1'b0;
      rsp_mask_in    = rsp_mask_ff;
      rsp_score_in   = rsp_score_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWN_ID: begin
               own_in    = csr_wdata[ID_W-1:0];
               leader_in = LEAD_W'(csr_wdata[ID_W-1:0]);
            end
            CSR_TIMEOUT: timeout_in = csr_wdata;
            CSR_MARGIN:  margin_in  = csr_wdata[SCORE_W-1:0];
            CSR_HOLDOFF: holdoff_in = csr_wdata;
            default: begin
               own_in = own_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in      = req_mode;
               req_score_in = req_score_value;
               fresh_in     = req_local_fresh;
               healthy_in   = req_local_healthy;
               now_in       = TIME_BITS'(req_now_us);
               best_id_in   = leader_ff;
               cnt_in       = '0;
               if (mode_type'(req_mode) == MODE_PEER) begin
                  if (peer_in_range) begin
                     score_in[peer_idx[IDX_W-1:0]] = sat_score(req_score_value);
                     seen_in[peer_idx[IDX_W-1:0]]  = TIME_BITS'(req_now_us);
                     valid_in[peer_idx[IDX_W-1:0]] = 1'b1;
                  end
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_EXPIRE;
               end
            end
         end
         ST_EXPIRE: begin
            if (rd_valid && gt) begin
               valid_in[cnt_ff] = 1'b0;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_LOCAL;
            end
         end
         ST_LOCAL: begin
            local_in      = local_new;
            holdoff_ok_in = gt;
            if (own_in_range) begin
               score_in[own_idx[IDX_W-1:0]] = local_new;
               seen_in[own_idx[IDX_W-1:0]]  = now_ff;
               valid_in[own_idx[IDX_W-1:0]] = 1'b1;
            end
            state_in = ST_LEAD;
         end
         ST_LEAD: begin
            best_in    = (leader_in_range && rd_valid) ? rd_score : SCORE_MAX;
            best_id_in = leader_ff;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_valid && (LEAD_W'(cnt_ff) != leader_ff) && !borrow && gt
                && holdoff_ok_ff) begin
               best_in    = rd_score;
               best_id_in = LEAD_W'(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_changed_in = 1'b0;
            rsp_leader_in  = leader_ff[ID_W-1:0];
            if (best_id_ff != leader_ff) begin
               leader_in      = best_id_ff;
               last_change_in = now_ff;
               rsp_changed_in = 1'b1;
               rsp_leader_in  = best_id_ff[ID_W-1:0];
            end
            rsp_valid_in = 1'b1;
            rsp_mask_in  = mask_now;
            rsp_score_in = local_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         own_ff         <= OWN_ID_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         margin_ff      <= MARGIN_RESET;
         holdoff_ff     <= HOLDOFF_RESET;
         leader_ff      <= LEAD_W'(OWN_ID_RESET);
         last_change_ff <= '0;
         local_ff       <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_changed_ff <= 1'b0;
         for (int i = 0; i < NODE_COUNT; i++) begin
            score_ff[i] <= '0;
            seen_ff[i]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         own_ff         <= own_in;
         timeout_ff     <= timeout_in;
         margin_ff      <= margin_in;
         holdoff_ff     <= holdoff_in;
         leader_ff      <= leader_in;
         last_change_ff <= last_change_in;
         local_ff       <= local_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_changed_ff <= rsp_changed_in;
         score_ff       <= score_in;
         seen_ff        <= seen_in;
      end
      mode_ff       <= mode_in;
      req_score_ff  <= req_score_in;
      fresh_ff      <= fresh_in;
      healthy_ff    <= healthy_in;
      now_ff        <= now_in;
      best_ff       <= best_in;
      best_id_ff    <= best_id_in;
      holdoff_ok_ff <= holdoff_ok_in;
      rsp_leader_ff <= rsp_leader_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_score_ff  <= rsp_score_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_leader_id      = rsp_leader_ff;
   assign rsp_leader_changed = rsp_changed_ff;
   assign rsp_valid_mask     = rsp_mask_ff;
   assign rsp_self_score_out = rsp_score_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("Response strobe raised while a request is still in progress.");

   a_change_flag_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_changed_ff |-> rsp_valid_ff)
      else $error("Leader change flag set without a response strobe.");

   a_new_leader_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> leader_in_range)
      else $error("Leader changed to a node index outside the table.");

   a_own_entry_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && (mode_type'(mode_ff) == MODE_TICK) && own_in_range)
      |-> valid_ff[own_idx[IDX_W-1:0]])
      else $error("Own node entry not valid at the end of a tick.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted request did not make the block busy.");
`endif

endmodule
